FILE: design/ebfr_pkg.sv
// Shared types and constants for the escaped byte frame receiver.
// Used by the channel interfaces and by the top level; depends on nothing.
package ebfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 9;   // reported frame length, low bits of the count
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;   // widest register is min_length
  localparam int MAX_LEN_DEF = 256;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE  = 3'd0,
    REG_STOP_BYTE   = 3'd1,
    REG_ESCAPE_BYTE = 3'd2,
    REG_XOR_MASK    = 3'd3,
    REG_MIN_LENGTH  = 3'd4
  } ebfr_reg_t;

  // One result item
  typedef struct packed {
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] data_index;
    logic              frame_done;
    logic              frame_good;
    logic [LEN_W-1:0]  frame_length;
    logic              frame_overflow;
  } ebfr_result_t;

endpackage

FILE: design/ebfr_in_if.sv
// Input request channel of the escaped byte frame receiver: one received byte.
// Depends on ebfr_pkg for the byte width.
interface ebfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [ebfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/ebfr_out_if.sv
// Result request channel of the escaped byte frame receiver.
// Depends on ebfr_pkg for field widths.
interface ebfr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        data_valid;
  logic [ebfr_pkg::BYTE_W-1:0] data_byte;
  logic [ebfr_pkg::BYTE_W-1:0] data_index;
  logic                        frame_done;
  logic                        frame_good;
  logic [ebfr_pkg::LEN_W-1:0]  frame_length;
  logic                        frame_overflow;

  modport source (output valid, output data_valid, output data_byte, output data_index,
                  output frame_done, output frame_good, output frame_length,
                  output frame_overflow, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input data_index,
                  input frame_done, input frame_good, input frame_length,
                  input frame_overflow, output ready);
endinterface

FILE: design/escaped_byte_frame_receiver_unit.sv
// Escaped byte frame receiver: byte-stuffing deframer with a result register.
// Depends on ebfr_pkg, ebfr_in_if and ebfr_out_if.
//
//   channel  direction  handshake      payload
//   in_rx    in         valid/ready    rx_byte
//   out_res  out        valid/ready    data_valid, data_byte, data_index, frame_done,
//                                      frame_good, frame_length, frame_overflow
//   cfg      in         cfg_we         cfg_index, cfg_wdata
//
// Every accepted byte yields exactly one result request, registered in the cycle after the accept.
// One byte per cycle while the result register is free or being drained: the frame state and
// the result register load on the accept, through three byte compares and the length counter.
// Input is taken while the result register is empty or being drained in that cycle.
// Synchronous active-low reset clears the frame state, config registers and the result valid.
module escaped_byte_frame_receiver_unit #(
  parameter int MAX_LEN = ebfr_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ebfr_in_if.sink                         in_rx,
  ebfr_out_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [ebfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ebfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // Configuration registers
  logic [BYTE_W-1:0] start_byte_r, stop_byte_r, escape_byte_r, xor_mask_r;
  logic [LEN_W-1:0]  min_length_r;

  // Frame state
  logic             in_frame_r, in_frame_nxt;
  logic             escape_pending_r, escape_pending_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             overflowed_r, overflowed_nxt;

  // Result register
  logic         out_valid_r;
  ebfr_result_t res_r, res_nxt;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              is_start, is_stop, is_esc, is_data, room;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= '0;
      stop_byte_r   <= '0;
      escape_byte_r <= '0;
      xor_mask_r    <= '0;
      min_length_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:  start_byte_r  <= cfg_wdata[BYTE_W-1:0];
        REG_STOP_BYTE:   stop_byte_r   <= cfg_wdata[BYTE_W-1:0];
        REG_ESCAPE_BYTE: escape_byte_r <= cfg_wdata[BYTE_W-1:0];
        REG_XOR_MASK:    xor_mask_r    <= cfg_wdata[BYTE_W-1:0];
        REG_MIN_LENGTH:  min_length_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a request when the result register is free or draining
  assign in_rx.ready = !out_valid_r || out_res.ready;
  assign accept      = in_rx.valid && in_rx.ready;
  assign b           = in_rx.rx_byte;

  // Classify the byte; start beats stop, stop beats escape
  assign is_start = (b == start_byte_r);
  assign is_stop  = !is_start && (b == stop_byte_r);
  assign is_esc   = !is_start && !is_stop && (b == escape_byte_r);
  assign is_data  = !is_start && !is_stop && !is_esc && in_frame_r;
  assign room     = (byte_count_r < MAX_CNT);

  // Advance frame state and build the result
  always_comb begin
    in_frame_nxt       = in_frame_r;
    escape_pending_nxt = escape_pending_r;
    byte_count_nxt     = byte_count_r;
    overflowed_nxt     = overflowed_r;
    res_nxt            = '0;
    if (is_start) begin
      in_frame_nxt       = 1'b1;
      escape_pending_nxt = 1'b0;
      byte_count_nxt     = '0;
      overflowed_nxt     = 1'b0;
    end else if (is_stop) begin
      in_frame_nxt           = 1'b0;
      escape_pending_nxt     = 1'b0;
      res_nxt.frame_done     = 1'b1;
      res_nxt.frame_good     = (CMP_W'(byte_count_r) >= CMP_W'(min_length_r)) && !overflowed_r;
      res_nxt.frame_length   = LEN_W'(byte_count_r);
      res_nxt.frame_overflow = overflowed_r;
    end else if (is_esc) begin
      escape_pending_nxt = 1'b1;
    end else if (is_data) begin
      escape_pending_nxt = 1'b0;
      if (room) begin
        res_nxt.data_valid = 1'b1;
        res_nxt.data_byte  = escape_pending_r ? (b ^ xor_mask_r) : b;
        res_nxt.data_index = BYTE_W'(byte_count_r);
        byte_count_nxt     = byte_count_r + 1'b1;
      end else begin
        overflowed_nxt = 1'b1;
      end
    end
  end

  // Hold frame state; update on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r       <= 1'b0;
      escape_pending_r <= 1'b0;
      byte_count_r     <= '0;
      overflowed_r     <= 1'b0;
    end else if (accept) begin
      in_frame_r       <= in_frame_nxt;
      escape_pending_r <= escape_pending_nxt;
      byte_count_r     <= byte_count_nxt;
      overflowed_r     <= overflowed_nxt;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.data_valid     = res_r.data_valid;
  assign out_res.data_byte      = res_r.data_byte;
  assign out_res.data_index     = res_r.data_index;
  assign out_res.frame_done     = res_r.frame_done;
  assign out_res.frame_good     = res_r.frame_good;
  assign out_res.frame_length   = res_r.frame_length;
  assign out_res.frame_overflow = res_r.frame_overflow;

  // A result carries either a payload byte or a frame report, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.data_valid && res_r.frame_done))
    else $error("result carries both payload and frame report");

  // The length counter never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= MAX_CNT)
    else $error("byte count beyond capacity");

  // Overflow is only flagged with the counter pinned at capacity
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflowed_r |-> (byte_count_r == MAX_CNT))
    else $error("overflow flagged below capacity");

  // A good frame report never comes with overflow
  a_good_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_good) |-> (res_r.frame_done && !res_r.frame_overflow))
    else $error("good frame reported with overflow or without stop");

endmodule
